[rtl/sfb_pkg.sv]
// sfb_pkg: shared widths, register indexes and word types of the seam feather blender.
// Used by every module under rtl/; depends on nothing.
`timescale 1ns / 1ps

package sfb_pkg;

    localparam int COL_W      = 12;               // pixel column
    localparam int PIX_W      = 8;                // one color channel
    localparam int WID_W      = 13;               // image width, overlap span
    localparam int NUM_W      = 20;               // weighted channel sum, <= 255 * 4096
    localparam int N_CH       = 3;
    localparam int DIV_STAGES = PIX_W;            // one quotient bit per stage
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = 1;
    localparam int Q_CW       = 2;

    localparam logic [WID_W-1:0] MAX_WIDTH = 13'd4096;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd1;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [PIX_W-1:0] first_ch0;
        logic [PIX_W-1:0] first_ch1;
        logic [PIX_W-1:0] first_ch2;
        logic [PIX_W-1:0] warped_ch0;
        logic [PIX_W-1:0] warped_ch1;
        logic [PIX_W-1:0] warped_ch2;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] blend_ch0;
        logic [PIX_W-1:0] blend_ch1;
        logic [PIX_W-1:0] blend_ch2;
        logic             written;
    } t_pix_out;

    // one queued job: quotient num / span per channel, plus the written flag
    typedef struct packed {
        logic [N_CH-1:0][NUM_W-1:0] num;
        logic [WID_W-1:0]           span;
        logic                       written;
    } t_job;

    typedef struct packed {
        logic valid;   // head word present
        logic full;
    } t_q_stat;

endpackage

[rtl/sfb_front.sv]
// sfb_front: config registers, overlap classification and weighted sums.
// Depends on sfb_pkg; pushes one job word per accepted pixel into sfb_queue.
`timescale 1ns / 1ps

module sfb_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  sfb_pkg::t_pix_in              i_pix,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sfb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sfb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  sfb_pkg::t_q_stat              i_q_stat,
    output logic                          o_push,
    output sfb_pkg::t_job                 o_job
);
    import sfb_pkg::*;

    logic [COL_W-1:0] r_start;
    logic [WID_W-1:0] r_width;

    logic             r_s1_valid;
    logic             r_s1_written;
    logic [WID_W-1:0] r_s1_wa;
    logic [COL_W-1:0] r_s1_wb;
    logic [WID_W-1:0] r_s1_span;
    logic [N_CH-1:0][PIX_W-1:0] r_s1_p;
    logic [N_CH-1:0][PIX_W-1:0] r_s1_q;

    logic             n_written;
    logic [WID_W-1:0] n_wa;
    logic [COL_W-1:0] n_wb;
    logic [WID_W-1:0] n_span;
    logic [WID_W-1:0] w_width_eff;
    logic [WID_W-1:0] w_col_ext;
    logic             w_in_range;
    logic             w_black;
    logic             w_accept;
    logic             w_s1_adv;
    logic [N_CH-1:0][PIX_W-1:0] w_p;
    logic [N_CH-1:0][PIX_W-1:0] w_q;

    assign o_cfg_ready = i_rst_n;
    assign o_busy      = !i_rst_n || (r_s1_valid && i_q_stat.full);
    assign w_accept    = i_start && !o_busy;
    assign w_s1_adv    = !r_s1_valid || !i_q_stat.full;

    assign w_p = {i_pix.first_ch2, i_pix.first_ch1, i_pix.first_ch0};
    assign w_q = {i_pix.warped_ch2, i_pix.warped_ch1, i_pix.warped_ch0};

    always_comb begin
        w_width_eff = (r_width > MAX_WIDTH) ? MAX_WIDTH : r_width;
        w_col_ext   = {1'b0, i_pix.column};
        w_in_range  = (i_pix.column >= r_start) && (w_col_ext < w_width_eff);
        w_black     = (w_q == '0);
        if (!w_in_range) begin
            // outside the overlap: 0 / 1 gives zero channels
            n_written = 1'b0;
            n_wa      = '0;
            n_wb      = '0;
            n_span    = WID_W'(1);
        end else if (w_black) begin
            // black warped pixel: p * 1 / 1 copies the first pixel
            n_written = 1'b1;
            n_wa      = WID_W'(1);
            n_wb      = '0;
            n_span    = WID_W'(1);
        end else begin
            n_written = 1'b1;
            n_wa      = w_width_eff - w_col_ext;
            n_wb      = i_pix.column - r_start;
            n_span    = w_width_eff - {1'b0, r_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start    <= '0;
            r_width    <= MAX_WIDTH;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_OVERLAP_START: r_start <= i_cfg_data[COL_W-1:0];
                    CFG_IMAGE_WIDTH:   r_width <= i_cfg_data[WID_W-1:0];
                    default:           ;
                endcase
            end
            if (w_s1_adv) begin
                r_s1_valid <= w_accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && w_accept) begin
            r_s1_written <= n_written;
            r_s1_wa      <= n_wa;
            r_s1_wb      <= n_wb;
            r_s1_span    <= n_span;
            r_s1_p       <= w_p;
            r_s1_q       <= w_q;
        end
    end

    // weighted sums; each fits NUM_W since the result is at most 255 * span
    always_comb begin
        for (int c = 0; c < N_CH; c++) begin
            o_job.num[c] = NUM_W'((NUM_W + 1)'(r_s1_p[c]) * (NUM_W + 1)'(r_s1_wa)
                                + (NUM_W + 1)'(r_s1_q[c]) * (NUM_W + 1)'(r_s1_wb));
        end
        o_job.span    = r_s1_span;
        o_job.written = r_s1_written;
    end

    assign o_push = r_s1_valid && !i_q_stat.full;

    a_busy_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_busy |-> r_s1_valid && i_q_stat.full)
        else $error("busy without a stalled word in stage 1");

endmodule

[rtl/sfb_queue.sv]
// sfb_queue: two-word job queue between the front and the divider back end.
// Depends on sfb_pkg (t_job, t_q_stat, Q_DEPTH).
`timescale 1ns / 1ps

module sfb_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sfb_pkg::t_job    i_job,
    input  logic             i_pop,
    output sfb_pkg::t_job    o_job,
    output sfb_pkg::t_q_stat o_stat
);
    import sfb_pkg::*;

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_CW-1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_stat.valid = (r_count != '0);
    assign o_stat.full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_job        = r_mem[r_rptr];
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && o_stat.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH))
        else $error("queue count above depth");

    a_push_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into a full queue");

endmodule

[rtl/sfb_back.sv]
// sfb_back: pipelined restoring divider, one quotient bit per stage, three channels.
// Depends on sfb_pkg; pops the queue head every cycle it holds a word.
`timescale 1ns / 1ps

module sfb_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sfb_pkg::t_q_stat i_q_stat,
    input  sfb_pkg::t_job    i_job,
    output logic             o_pop,
    output logic             o_strobe,
    output sfb_pkg::t_pix_out o_res
);
    import sfb_pkg::*;

    logic                              r_vld  [DIV_STAGES];
    logic                              r_wr   [DIV_STAGES];
    logic [WID_W-1:0]                  r_span [DIV_STAGES];
    logic [N_CH-1:0][NUM_W-1:0]        r_rem  [DIV_STAGES];
    logic [N_CH-1:0][PIX_W-1:0]        r_quo  [DIV_STAGES];

    logic                              s_vld  [DIV_STAGES];
    logic                              s_wr   [DIV_STAGES];
    logic [WID_W-1:0]                  s_span [DIV_STAGES];
    logic [N_CH-1:0][NUM_W-1:0]        s_rem  [DIV_STAGES];
    logic [N_CH-1:0][PIX_W-1:0]        s_quo  [DIV_STAGES];

    logic [N_CH-1:0][NUM_W-1:0]        n_rem  [DIV_STAGES];
    logic [N_CH-1:0][PIX_W-1:0]        n_quo  [DIV_STAGES];

    assign o_pop = i_q_stat.valid;

    // stage inputs: stage 0 from the queue head, later ones from the stage before
    always_comb begin
        s_vld[0]  = i_q_stat.valid;
        s_wr[0]   = i_job.written;
        s_span[0] = i_job.span;
        s_rem[0]  = i_job.num;
        s_quo[0]  = '0;
        for (int s = 1; s < DIV_STAGES; s++) begin
            s_vld[s]  = r_vld[s-1];
            s_wr[s]   = r_wr[s-1];
            s_span[s] = r_span[s-1];
            s_rem[s]  = r_rem[s-1];
            s_quo[s]  = r_quo[s-1];
        end
    end

    // stage s settles quotient bit DIV_STAGES-1-s; remainder stays below span << bit
    always_comb begin
        logic [NUM_W:0] dsh;
        for (int s = 0; s < DIV_STAGES; s++) begin
            dsh = (NUM_W + 1)'(s_span[s]) << (DIV_STAGES - 1 - s);
            for (int c = 0; c < N_CH; c++) begin
                n_quo[s][c] = s_quo[s][c];
                if ({1'b0, s_rem[s][c]} >= dsh) begin
                    n_rem[s][c] = s_rem[s][c] - dsh[NUM_W-1:0];
                    n_quo[s][c][DIV_STAGES-1-s] = 1'b1;
                end else begin
                    n_rem[s][c] = s_rem[s][c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_vld[s] <= s_vld[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            r_wr[s]   <= s_wr[s];
            r_span[s] <= s_span[s];
            r_rem[s]  <= n_rem[s];
            r_quo[s]  <= n_quo[s];
        end
    end

    assign o_strobe        = r_vld[DIV_STAGES-1];
    assign o_res.blend_ch0 = r_quo[DIV_STAGES-1][0];
    assign o_res.blend_ch1 = r_quo[DIV_STAGES-1][1];
    assign o_res.blend_ch2 = r_quo[DIV_STAGES-1][2];
    assign o_res.written   = r_wr[DIV_STAGES-1];

    a_unwritten_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_res.written |->
            o_res.blend_ch0 == '0 && o_res.blend_ch1 == '0 && o_res.blend_ch2 == '0)
        else $error("pixel outside the overlap carries nonzero channels");

endmodule

[rtl/seam_feather_blend.sv]
// seam_feather_blend: linear feather blend of one pixel per clock across the seam overlap.
// Path from the edge that accepts start to o_strobe: stage 1, queue, 8-stage divider.
// Throughput: one pixel per cycle, set by the divider pipeline.
// The receiver cannot stall, so busy stays low outside reset; busy is high during reset.
// Reset (i_rst_n low, synchronous) empties the pipeline, overlap_start = 0, width = 4096.
// Depends on sfb_pkg, sfb_front, sfb_queue, sfb_back.
`timescale 1ns / 1ps

module seam_feather_blend (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  sfb_pkg::t_pix_in               i_pix,
    output logic                           o_strobe,
    output sfb_pkg::t_pix_out              o_res,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sfb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sfb_pkg::*;

    t_q_stat w_q_stat;
    t_job    w_push_job;
    t_job    w_head_job;
    logic    w_push;
    logic    w_pop;
    logic    w_accept;

    assign w_accept = start && !busy;

    sfb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_pix       (i_pix),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    sfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_stat  (w_q_stat)
    );

    sfb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_job    (w_head_job),
        .o_pop    (w_pop),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    // the word is taken only for a pixel accepted earlier, through stage 1, the queue and the divider stages
    a_strobe_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept, 10))
        else $error("result word without an accepted pixel ten edges earlier");

endmodule

[bench/tb.sv]
// tb: self-checking bench for seam_feather_blend, with directed pixels and random pixel
// streams over a range of overlap settings. Depends on rtl/sfb_pkg.sv and the blender RTL.
`timescale 1ns / 1ps

module tb;
    import sfb_pkg::*;

    localparam int QUIET_LIMIT = 2000;   // cycles with no handshake before giving up
    localparam int TAIL_CYCLES = 12;     // extra wait after the drain before the final check

    // Keeps the blender's register copy and the queue of pixels still due.
    class seam_checker;
        logic [COL_W-1:0] ov_start;
        logic [WID_W-1:0] img_width;
        t_pix_out         due_pixels[$];
        int               mismatches;

        function new();
            ov_start   = '0;
            img_width  = MAX_WIDTH;
            mismatches = 0;
        endfunction

        function void note_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_OVERLAP_START) begin
                ov_start = data[COL_W-1:0];
            end else if (idx == CFG_IMAGE_WIDTH) begin
                img_width = data;
            end
        endfunction

        function t_pix_out feather_mix(t_pix_in px);
            t_pix_out    r;
            int unsigned w, s, c, span, wa, wb;
            int unsigned p[3], q[3], mix[3];
            w = (img_width > MAX_WIDTH) ? 32'(MAX_WIDTH) : 32'(img_width);
            s = 32'(ov_start);
            c = 32'(px.column);
            p = '{32'(px.first_ch0), 32'(px.first_ch1), 32'(px.first_ch2)};
            q = '{32'(px.warped_ch0), 32'(px.warped_ch1), 32'(px.warped_ch2)};
            r = '0;
            if (c < s || c >= w) begin
                return r;
            end
            if (q[0] == 0 && q[1] == 0 && q[2] == 0) begin
                mix = p;    // black warped pixel: keep the first image
            end else begin
                span = w - s;
                wa   = w - c;
                wb   = c - s;
                for (int k = 0; k < 3; k++) begin
                    mix[k] = (p[k] * wa + q[k] * wb) / span;
                end
            end
            r.blend_ch0 = mix[0][PIX_W-1:0];
            r.blend_ch1 = mix[1][PIX_W-1:0];
            r.blend_ch2 = mix[2][PIX_W-1:0];
            r.written   = 1'b1;
            return r;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%t mismatch: %s", $realtime, msg);
            end
        endfunction

        function void note_pixel(t_pix_in px);
            due_pixels.insert(due_pixels.size(), feather_mix(px));
        endfunction

        function void check_pixel(t_pix_out got);
            t_pix_out want;
            if (due_pixels.size() == 0) begin
                flag($sformatf("unexpected word %h", got));
                return;
            end
            want = due_pixels.pop_front();
            if (got.blend_ch0 !== want.blend_ch0 || got.blend_ch1 !== want.blend_ch1 ||
                got.blend_ch2 !== want.blend_ch2 || got.written !== want.written) begin
                flag($sformatf("exp ch %0d/%0d/%0d wr %0b, got ch %0d/%0d/%0d wr %0b",
                               want.blend_ch0, want.blend_ch1, want.blend_ch2, want.written,
                               got.blend_ch0, got.blend_ch1, got.blend_ch2, got.written));
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_pix_in               i_pix;
    logic                  o_strobe;
    t_pix_out              o_res;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    seam_checker sb = new();
    int          quiet_cycles = 0;
    int          gap_pct = 0;

    seam_feather_blend dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_pix       (i_pix),
        .o_strobe    (o_strobe),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Observe every handshake at the edge that completes it; also the stall watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            quiet_cycles++;
            if (start && !busy) begin
                sb.note_pixel(i_pix);
                quiet_cycles = 0;
            end
            if (o_strobe) begin
                sb.check_pixel(o_res);
                quiet_cycles = 0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.note_reg(i_cfg_index, i_cfg_data);
                quiet_cycles = 0;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_pixel(t_pix_in px);
        start <= 1'b1;
        i_pix <= px;
        do @(posedge i_clk); while (busy);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // waits on the clock before it polls, so the last accepted pixel is already queued in the checker
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.due_pixels.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // registers change only with the pipeline empty
    task automatic set_overlap(logic [CFG_DATA_W-1:0] ofs, logic [CFG_DATA_W-1:0] wid);
        wait_drained();
        write_reg(CFG_OVERLAP_START, ofs);
        write_reg(CFG_IMAGE_WIDTH, wid);
    endtask

    function automatic t_pix_in mk(int c, int p0, int p1, int p2, int q0, int q1, int q2);
        t_pix_in px;
        px.column     = c[COL_W-1:0];
        px.first_ch0  = p0[PIX_W-1:0];
        px.first_ch1  = p1[PIX_W-1:0];
        px.first_ch2  = p2[PIX_W-1:0];
        px.warped_ch0 = q0[PIX_W-1:0];
        px.warped_ch1 = q1[PIX_W-1:0];
        px.warped_ch2 = q2[PIX_W-1:0];
        return px;
    endfunction

    function automatic int rand_chan();
        int r;
        r = $urandom_range(99);
        if (r < 8) return 0;
        if (r < 16) return 255;
        return $urandom_range(255);
    endfunction

    // mostly columns inside the current overlap, edges included
    function automatic t_pix_in rand_pixel();
        int unsigned w, s, c, r;
        t_pix_in     px;
        w = (sb.img_width > MAX_WIDTH) ? 32'(MAX_WIDTH) : 32'(sb.img_width);
        s = 32'(sb.ov_start);
        r = $urandom_range(99);
        if (s < w && r < 10) begin
            c = ($urandom_range(1) != 0) ? s : w - 1;
        end else if (s < w && r < 75) begin
            c = $urandom_range(w - 1, s);
        end else begin
            c = $urandom_range(4095);
        end
        px = mk(c, rand_chan(), rand_chan(), rand_chan(),
                rand_chan(), rand_chan(), rand_chan());
        if ($urandom_range(99) < 15) begin
            px.warped_ch0 = '0;
            px.warped_ch1 = '0;
            px.warped_ch2 = '0;
        end
        return px;
    endfunction

    logic [CFG_DATA_W-1:0] ofs_list[11] = '{13'd0, 13'd0, 13'd4095, 13'h1FFF, 13'd1,
                                           13'd100, 13'd2000, 13'd7, 13'd300, 13'd0, 13'd50};
    logic [CFG_DATA_W-1:0] wid_list[11] = '{13'd4096, 13'd1, 13'd4096, 13'd8191, 13'd2,
                                           13'd356, 13'd0, 13'd7, 13'd8191, 13'd4097, 13'd51};

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_pix       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_OVERLAP_START;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting: overlap is the whole row
        send_pixel(mk(0, 255, 255, 255, 255, 255, 255));
        send_pixel(mk(4095, 255, 255, 255, 255, 255, 255));
        send_pixel(mk(4095, 255, 0, 128, 1, 1, 1));
        send_pixel(mk(2048, 0, 0, 0, 255, 255, 255));
        send_pixel(mk(1, 255, 255, 255, 0, 0, 0));
        send_pixel(mk(3000, 17, 200, 99, 0, 0, 0));
        send_pixel(mk(2047, 170, 85, 255, 1, 0, 0));
        send_pixel(mk(4000, 85, 170, 0, 0, 0, 1));
        send_pixel(mk(1234, 0, 0, 0, 0, 0, 0));
        set_overlap(13'd100, 13'd356);
        send_pixel(mk(99, 200, 200, 200, 10, 10, 10));
        send_pixel(mk(100, 200, 200, 200, 10, 10, 10));
        send_pixel(mk(355, 200, 200, 200, 10, 10, 10));
        send_pixel(mk(356, 200, 200, 200, 10, 10, 10));
        send_pixel(mk(4095, 255, 255, 255, 255, 255, 255));
        set_overlap(13'd2000, 13'd0);
        send_pixel(mk(2000, 1, 2, 3, 4, 5, 6));
        send_pixel(mk(0, 1, 2, 3, 0, 0, 0));
        set_overlap(13'h1FFF, 13'd8191);
        send_pixel(mk(4095, 255, 0, 255, 0, 255, 0));
        send_pixel(mk(4094, 255, 0, 255, 0, 255, 0));

        for (int ph = 0; ph < 15; ph++) begin
            gap_pct = (ph < 5) ? 6 : (ph < 10) ? 49 : 0;
            if (ph < 11) begin
                set_overlap(ofs_list[ph], wid_list[ph]);
            end else begin
                set_overlap(CFG_DATA_W'($urandom_range(4095)),
                            CFG_DATA_W'($urandom_range(8191)));
            end
            for (int n = 0; n < 112; n++) begin
                send_pixel(rand_pixel());
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.due_pixels.size() != 0) begin
            sb.flag($sformatf("%0d words never came out", sb.due_pixels.size()));
        end
        if (sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
